// ----- src/ddo_pkg.sv -----
// Shared types, constants and tables of the differential-drive odometry block.
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [23:0]        INV_WB_RESET    = 24'd70017;
    localparam logic signed [31:0] HEIGHT_RESET    = 32'sd11141;
    localparam logic signed [32:0] RATE_TO_BAM     = 33'sd22399067;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE         = 34'sd1073741824;
    localparam logic [20:0]        DIV_CONST       = 21'd1000000;
    localparam logic [31:0]        DIV_RECIP       = 32'd2251799813;
    localparam logic [80:0]        SAT_THRESH      = 81'd8589934593000000;
    localparam logic [33:0]        STEP_LIMIT      = 34'h2_0000_0000;

    localparam logic [1:0] CFG_INV_WB = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [5:0] {
        S_IDLE, S_MW, S_UW, S_MK, S_UK, S_P0, S_P1, S_P2, S_P3, S_PA, S_ANG,
        S_CM, S_WM, S_CX, S_CY, S_X0, S_X1, S_Y0, S_Y1, S_UY1, S_DI, S_DQY, S_DRX,
        S_DRY, S_DRR, S_DF, S_POS, S_CN, S_WN, S_VX, S_VY, S_UVY, S_CH, S_WH, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        M_NONE, M_W, M_K, M_P0, M_P1, M_P2, M_P3, M_VCOS, M_VSIN,
        M_X0, M_X1, M_Y0, M_Y1, M_QX, M_QY, M_RX, M_RY
    } t_mul;

    typedef enum logic [4:0] {
        OP_NONE, OP_PRIME, OP_LOAD, OP_U_W, OP_U_K, OP_U_P0, OP_U_P1, OP_U_P2,
        OP_U_P3, OP_ANGLE, OP_START_MID, OP_START_NEW, OP_START_HALF, OP_U_CX,
        OP_U_CY, OP_U_X0, OP_U_X1, OP_U_Y0, OP_U_Y1, OP_DIV_INIT, OP_U_QX,
        OP_U_QY, OP_U_RX, OP_U_RY, OP_DIV_FIX, OP_POS, OP_U_VX, OP_U_VY, OP_OUT
    } t_op;

    typedef struct packed {
        t_mul mul;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
        logic out_full;
    } t_status;

    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051D;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2E;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/differential_drive_odometry_top.sv -----
// Top level of the differential-drive odometry block with midpoint pose integration.
//
// Channel    Direction  Handshake                      Contents
// s_axis     in         s_axis_tvalid/s_axis_tready    wheel speeds and time stamp
// m_axis     out        m_axis_tvalid/m_axis_tready    pose, quaternion, velocity, yaw rate
// cfg        in         i_cfg_wr_en                    inverse wheel base, height
//
// The first item after reset only records its stamp and gives no result.
// Every later item keeps the block busy after its accept, mostly for the three passes of the
// single iterative CORDIC; once the output register is loaded the block returns to idle, and
// the next item can then be accepted.
// Only one item is in work at a time; s_axis_tready is high only while idle.
// The result waits in the output register; a stalled output holds only the final load.
`default_nettype none
module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // right_speed[31:0], left_speed[63:32], stamp_us[111:64]
    input  wire logic [111:0]   s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_z, vel_x, vel_y, yaw_rate, 32 bits each
    output logic [255:0]        m_axis_tdata,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data
);
    ddo_pkg::t_cmd    cmd;
    ddo_pkg::t_status status;

    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ddo_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- src/ddo_cordic.sv -----
// Iterative rotation-mode CORDIC giving clamped Q2.30 cosine and sine of a binary angle.
`default_nettype none
module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_angle,
    output logic                    o_done,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);
    localparam int CW = $clog2(CORDIC_STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic               r_flip;
    logic signed [33:0] r_x, r_y, r_z;

    logic [31:0]        ang_q, ang_b;
    logic               flip;
    logic signed [33:0] dx, dy, at, fx, fy;

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = v;
        if (v > ddo_pkg::Q30_ONE) begin
            t = ddo_pkg::Q30_ONE;
        end else if (v < -ddo_pkg::Q30_ONE) begin
            t = -ddo_pkg::Q30_ONE;
        end
        return t[31:0];
    endfunction

    always_comb begin
        ang_q = i_angle + 32'h4000_0000;
        flip  = ang_q[31];
        ang_b = flip ? i_angle + 32'h8000_0000 : i_angle;
        dx    = r_y >>> r_cnt;
        dy    = r_x >>> r_cnt;
        at    = $signed({2'b00, ddo_pkg::atan_bam(5'(r_cnt))});
        fx    = r_flip ? -r_x : r_x;
        fy    = r_flip ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= flip;
            r_x    <= ddo_pkg::CORDIC_GAIN_INV;
            r_y    <= '0;
            r_z    <= {{2{ang_b[31]}}, ang_b};
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = clamp_q30(fx);
    assign o_sin  = clamp_q30(fy);

endmodule
`default_nettype wire

// ----- src/ddo_datapath.sv -----
// Datapath of the odometry block: pose state, shared multiplier, dividers and output register.
`default_nettype none
module ddo_datapath #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ddo_pkg::t_cmd    i_cmd,
    output ddo_pkg::t_status      o_status,
    input  wire logic [111:0]     i_in_data,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [31:0]      i_cfg_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [255:0]          o_out_data
);
    logic [23:0]        r_inv_wb;
    logic signed [31:0] r_height;
    logic signed [31:0] r_xacc, r_yacc;
    logic [31:0]        r_heading, r_mid;
    logic [47:0]        r_last, r_dt;
    logic signed [31:0] r_v, r_w, r_cos, r_sin, r_vx, r_vy;
    logic signed [32:0] r_diff;
    logic signed [56:0] r_k;
    logic [63:0]        r_p;
    logic signed [65:0] r_prod;
    logic               r_cx_neg, r_cy_neg, r_sx, r_sy;
    logic [31:0]        r_mx, r_my;
    logic [80:0]        r_ax, r_ay;
    logic [33:0]        r_qx, r_qy;
    logic [23:0]        r_rx, r_ry;
    logic               r_out_valid;
    logic [255:0]       r_out_data;

    logic signed [31:0] vr, vl;
    logic [47:0]        stamp;
    logic [63:0]        k64;
    logic signed [32:0] ma, mb, c33;
    logic signed [65:0] sh16, sh30;
    logic [33:0]        dmx, dmy;
    logic signed [35:0] stx, sty, sumx, sumy;
    logic               cor_start, cor_done;
    logic [31:0]        cor_angle;
    logic signed [31:0] cor_cos, cor_sin;

    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // The reciprocal estimate of the quotient is low by at most five.
    function automatic logic [33:0] div_fix(input logic [23:0] rem);
        logic [33:0] r;
        if (rem >= 24'd5000000) begin
            r = 34'd5;
        end else if (rem >= 24'd4000000) begin
            r = 34'd4;
        end else if (rem >= 24'd3000000) begin
            r = 34'd3;
        end else if (rem >= 24'd2000000) begin
            r = 34'd2;
        end else if (rem >= 24'd1000000) begin
            r = 34'd1;
        end else begin
            r = 34'd0;
        end
        return r;
    endfunction

    always_comb begin
        vr    = i_in_data[31:0];
        vl    = i_in_data[63:32];
        stamp = i_in_data[111:64];
        k64   = {{7{r_k[56]}}, r_k};
        sh16  = r_prod >>> 16;
        sh30  = r_prod >>> 30;
        c33   = sh30[32:0];
        dmx   = r_sx ? ddo_pkg::STEP_LIMIT : r_qx;
        dmy   = r_sy ? ddo_pkg::STEP_LIMIT : r_qy;
        stx   = r_cx_neg ? -$signed({2'b00, dmx}) : $signed({2'b00, dmx});
        sty   = r_cy_neg ? -$signed({2'b00, dmy}) : $signed({2'b00, dmy});
        sumx  = {{4{r_xacc[31]}}, r_xacc} + stx;
        sumy  = {{4{r_yacc[31]}}, r_yacc} + sty;
    end

    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.mul)
            ddo_pkg::M_W: begin
                ma = r_diff;
                mb = $signed({9'd0, r_inv_wb});
            end
            ddo_pkg::M_K: begin
                ma = {r_w[31], r_w};
                mb = ddo_pkg::RATE_TO_BAM;
            end
            ddo_pkg::M_P0: begin
                ma = $signed({1'b0, k64[31:0]});
                mb = $signed({9'd0, r_dt[23:0]});
            end
            ddo_pkg::M_P1: begin
                ma = $signed({1'b0, k64[31:0]});
                mb = $signed({9'd0, r_dt[47:24]});
            end
            ddo_pkg::M_P2: begin
                ma = $signed({1'b0, k64[63:32]});
                mb = $signed({9'd0, r_dt[23:0]});
            end
            ddo_pkg::M_P3: begin
                ma = $signed({1'b0, k64[63:32]});
                mb = $signed({9'd0, r_dt[47:24]});
            end
            ddo_pkg::M_VCOS: begin
                ma = {r_v[31], r_v};
                mb = {r_cos[31], r_cos};
            end
            ddo_pkg::M_VSIN: begin
                ma = {r_v[31], r_v};
                mb = {r_sin[31], r_sin};
            end
            ddo_pkg::M_X0: begin
                ma = $signed({1'b0, r_mx});
                mb = $signed({9'd0, r_dt[23:0]});
            end
            ddo_pkg::M_X1: begin
                ma = $signed({1'b0, r_mx});
                mb = $signed({9'd0, r_dt[47:24]});
            end
            ddo_pkg::M_Y0: begin
                ma = $signed({1'b0, r_my});
                mb = $signed({9'd0, r_dt[23:0]});
            end
            ddo_pkg::M_Y1: begin
                ma = $signed({1'b0, r_my});
                mb = $signed({9'd0, r_dt[47:24]});
            end
            ddo_pkg::M_QX: begin
                ma = $signed({1'b0, r_ax[52:21]});
                mb = $signed({1'b0, ddo_pkg::DIV_RECIP});
            end
            ddo_pkg::M_QY: begin
                ma = $signed({1'b0, r_ay[52:21]});
                mb = $signed({1'b0, ddo_pkg::DIV_RECIP});
            end
            ddo_pkg::M_RX: begin
                ma = $signed({9'd0, r_qx[23:0]});
                mb = $signed({12'd0, ddo_pkg::DIV_CONST});
            end
            ddo_pkg::M_RY: begin
                ma = $signed({9'd0, r_qy[23:0]});
                mb = $signed({12'd0, ddo_pkg::DIV_CONST});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb begin
        cor_start = 1'b0;
        cor_angle = r_mid;
        case (i_cmd.op)
            ddo_pkg::OP_START_MID: begin
                cor_start = 1'b1;
                cor_angle = r_mid;
            end
            ddo_pkg::OP_START_NEW: begin
                cor_start = 1'b1;
                cor_angle = r_heading;
            end
            ddo_pkg::OP_START_HALF: begin
                cor_start = 1'b1;
                cor_angle = {r_heading[31], r_heading[31:1]};
            end
            default: begin
                cor_start = 1'b0;
                cor_angle = r_mid;
            end
        endcase
    end

    ddo_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_wb    <= ddo_pkg::INV_WB_RESET;
            r_height    <= ddo_pkg::HEIGHT_RESET;
            r_xacc      <= '0;
            r_yacc      <= '0;
            r_heading   <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == ddo_pkg::CFG_INV_WB) begin
                    r_inv_wb <= i_cfg_data[23:0];
                end else if (i_cfg_index == ddo_pkg::CFG_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
            if (i_cmd.op == ddo_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                ddo_pkg::OP_PRIME: begin
                    r_last <= stamp;
                end
                ddo_pkg::OP_LOAD: begin
                    r_last <= stamp;
                end
                ddo_pkg::OP_ANGLE: begin
                    r_heading <= r_heading + r_p[62:31];
                end
                ddo_pkg::OP_POS: begin
                    r_xacc <= sat36(sumx);
                    r_yacc <= sat36(sumy);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        if (cor_done) begin
            r_cos <= cor_cos;
            r_sin <= cor_sin;
        end
        case (i_cmd.op)
            ddo_pkg::OP_LOAD: begin
                r_dt   <= stamp - r_last;
                r_v    <= 32'(($signed({vr[31], vr}) + $signed({vl[31], vl})) >>> 1);
                r_diff <= $signed({vr[31], vr}) - $signed({vl[31], vl});
            end
            ddo_pkg::OP_U_W:  r_w <= sat66(sh16);
            ddo_pkg::OP_U_K:  r_k <= r_prod[56:0];
            ddo_pkg::OP_U_P0: r_p <= r_prod[63:0];
            ddo_pkg::OP_U_P1: r_p <= r_p + {r_prod[39:0], 24'd0};
            ddo_pkg::OP_U_P2: r_p <= r_p + {r_prod[31:0], 32'd0};
            ddo_pkg::OP_U_P3: r_p <= r_p + {r_prod[7:0], 56'd0};
            ddo_pkg::OP_ANGLE: r_mid <= r_heading + r_p[63:32];
            ddo_pkg::OP_U_CX: begin
                r_cx_neg <= c33[32];
                r_mx     <= c33[32] ? 32'(-c33) : c33[31:0];
            end
            ddo_pkg::OP_U_CY: begin
                r_cy_neg <= c33[32];
                r_my     <= c33[32] ? 32'(-c33) : c33[31:0];
            end
            ddo_pkg::OP_U_X0: r_ax <= {25'd0, r_prod[55:0]};
            ddo_pkg::OP_U_X1: r_ax <= r_ax + {1'b0, r_prod[55:0], 24'd0};
            ddo_pkg::OP_U_Y0: r_ay <= {25'd0, r_prod[55:0]};
            ddo_pkg::OP_U_Y1: r_ay <= r_ay + {1'b0, r_prod[55:0], 24'd0};
            ddo_pkg::OP_DIV_INIT: begin
                r_sx <= r_ax >= ddo_pkg::SAT_THRESH;
                r_sy <= r_ay >= ddo_pkg::SAT_THRESH;
            end
            ddo_pkg::OP_U_QX: r_qx <= r_prod[63:30];
            ddo_pkg::OP_U_QY: r_qy <= r_prod[63:30];
            ddo_pkg::OP_U_RX: r_rx <= r_ax[23:0] - r_prod[23:0];
            ddo_pkg::OP_U_RY: r_ry <= r_ay[23:0] - r_prod[23:0];
            ddo_pkg::OP_DIV_FIX: begin
                r_qx <= r_qx + div_fix(r_rx);
                r_qy <= r_qy + div_fix(r_ry);
            end
            ddo_pkg::OP_U_VX: r_vx <= sat66(sh30);
            ddo_pkg::OP_U_VY: r_vy <= sat66(sh30);
            ddo_pkg::OP_OUT: begin
                r_out_data <= {r_w, r_vy, r_vx, r_sin, r_cos,
                               r_height, r_yacc, r_xacc};
            end
            default: begin
            end
        endcase
    end

    assign o_status.cordic_done = cor_done;
    assign o_status.out_full    = r_out_valid && !i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_out_data           = r_out_data;

endmodule
`default_nettype wire

// ----- src/ddo_ctrl.sv -----
// Controller state machine that sequences the odometry datapath for each item.
`default_nettype none
module ddo_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ddo_pkg::t_status  i_status,
    output ddo_pkg::t_cmd          o_cmd
);
    ddo_pkg::t_state r_state, n_state;
    logic            r_primed, n_primed;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ddo_pkg::S_IDLE;
            r_primed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_primed <= n_primed;
        end
    end

    assign accept = i_in_valid && (r_state == ddo_pkg::S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_primed   = r_primed;
        o_cmd.mul  = ddo_pkg::M_NONE;
        o_cmd.op   = ddo_pkg::OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ddo_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_primed) begin
                        o_cmd.op = ddo_pkg::OP_LOAD;
                        n_state  = ddo_pkg::S_MW;
                    end else begin
                        o_cmd.op = ddo_pkg::OP_PRIME;
                        n_primed = 1'b1;
                    end
                end
            end
            ddo_pkg::S_MW: begin
                o_cmd.mul = ddo_pkg::M_W;
                n_state   = ddo_pkg::S_UW;
            end
            ddo_pkg::S_UW: begin
                o_cmd.op = ddo_pkg::OP_U_W;
                n_state  = ddo_pkg::S_MK;
            end
            ddo_pkg::S_MK: begin
                o_cmd.mul = ddo_pkg::M_K;
                n_state   = ddo_pkg::S_UK;
            end
            ddo_pkg::S_UK: begin
                o_cmd.op = ddo_pkg::OP_U_K;
                n_state  = ddo_pkg::S_P0;
            end
            ddo_pkg::S_P0: begin
                o_cmd.mul = ddo_pkg::M_P0;
                n_state   = ddo_pkg::S_P1;
            end
            ddo_pkg::S_P1: begin
                o_cmd.mul = ddo_pkg::M_P1;
                o_cmd.op  = ddo_pkg::OP_U_P0;
                n_state   = ddo_pkg::S_P2;
            end
            ddo_pkg::S_P2: begin
                o_cmd.mul = ddo_pkg::M_P2;
                o_cmd.op  = ddo_pkg::OP_U_P1;
                n_state   = ddo_pkg::S_P3;
            end
            ddo_pkg::S_P3: begin
                o_cmd.mul = ddo_pkg::M_P3;
                o_cmd.op  = ddo_pkg::OP_U_P2;
                n_state   = ddo_pkg::S_PA;
            end
            ddo_pkg::S_PA: begin
                o_cmd.op = ddo_pkg::OP_U_P3;
                n_state  = ddo_pkg::S_ANG;
            end
            ddo_pkg::S_ANG: begin
                o_cmd.op = ddo_pkg::OP_ANGLE;
                n_state  = ddo_pkg::S_CM;
            end
            ddo_pkg::S_CM: begin
                o_cmd.op = ddo_pkg::OP_START_MID;
                n_state  = ddo_pkg::S_WM;
            end
            ddo_pkg::S_WM: begin
                if (i_status.cordic_done) begin
                    n_state = ddo_pkg::S_CX;
                end
            end
            ddo_pkg::S_CX: begin
                o_cmd.mul = ddo_pkg::M_VCOS;
                n_state   = ddo_pkg::S_CY;
            end
            ddo_pkg::S_CY: begin
                o_cmd.mul = ddo_pkg::M_VSIN;
                o_cmd.op  = ddo_pkg::OP_U_CX;
                n_state   = ddo_pkg::S_X0;
            end
            ddo_pkg::S_X0: begin
                o_cmd.mul = ddo_pkg::M_X0;
                o_cmd.op  = ddo_pkg::OP_U_CY;
                n_state   = ddo_pkg::S_X1;
            end
            ddo_pkg::S_X1: begin
                o_cmd.mul = ddo_pkg::M_X1;
                o_cmd.op  = ddo_pkg::OP_U_X0;
                n_state   = ddo_pkg::S_Y0;
            end
            ddo_pkg::S_Y0: begin
                o_cmd.mul = ddo_pkg::M_Y0;
                o_cmd.op  = ddo_pkg::OP_U_X1;
                n_state   = ddo_pkg::S_Y1;
            end
            ddo_pkg::S_Y1: begin
                o_cmd.mul = ddo_pkg::M_Y1;
                o_cmd.op  = ddo_pkg::OP_U_Y0;
                n_state   = ddo_pkg::S_UY1;
            end
            ddo_pkg::S_UY1: begin
                o_cmd.op = ddo_pkg::OP_U_Y1;
                n_state  = ddo_pkg::S_DI;
            end
            ddo_pkg::S_DI: begin
                o_cmd.mul = ddo_pkg::M_QX;
                o_cmd.op  = ddo_pkg::OP_DIV_INIT;
                n_state   = ddo_pkg::S_DQY;
            end
            ddo_pkg::S_DQY: begin
                o_cmd.mul = ddo_pkg::M_QY;
                o_cmd.op  = ddo_pkg::OP_U_QX;
                n_state   = ddo_pkg::S_DRX;
            end
            ddo_pkg::S_DRX: begin
                o_cmd.mul = ddo_pkg::M_RX;
                o_cmd.op  = ddo_pkg::OP_U_QY;
                n_state   = ddo_pkg::S_DRY;
            end
            ddo_pkg::S_DRY: begin
                o_cmd.mul = ddo_pkg::M_RY;
                o_cmd.op  = ddo_pkg::OP_U_RX;
                n_state   = ddo_pkg::S_DRR;
            end
            ddo_pkg::S_DRR: begin
                o_cmd.op = ddo_pkg::OP_U_RY;
                n_state  = ddo_pkg::S_DF;
            end
            ddo_pkg::S_DF: begin
                o_cmd.op = ddo_pkg::OP_DIV_FIX;
                n_state  = ddo_pkg::S_POS;
            end
            ddo_pkg::S_POS: begin
                o_cmd.op = ddo_pkg::OP_POS;
                n_state  = ddo_pkg::S_CN;
            end
            ddo_pkg::S_CN: begin
                o_cmd.op = ddo_pkg::OP_START_NEW;
                n_state  = ddo_pkg::S_WN;
            end
            ddo_pkg::S_WN: begin
                if (i_status.cordic_done) begin
                    n_state = ddo_pkg::S_VX;
                end
            end
            ddo_pkg::S_VX: begin
                o_cmd.mul = ddo_pkg::M_VCOS;
                n_state   = ddo_pkg::S_VY;
            end
            ddo_pkg::S_VY: begin
                o_cmd.mul = ddo_pkg::M_VSIN;
                o_cmd.op  = ddo_pkg::OP_U_VX;
                n_state   = ddo_pkg::S_UVY;
            end
            ddo_pkg::S_UVY: begin
                o_cmd.op = ddo_pkg::OP_U_VY;
                n_state  = ddo_pkg::S_CH;
            end
            ddo_pkg::S_CH: begin
                o_cmd.op = ddo_pkg::OP_START_HALF;
                n_state  = ddo_pkg::S_WH;
            end
            ddo_pkg::S_WH: begin
                if (i_status.cordic_done) begin
                    n_state = ddo_pkg::S_OUT;
                end
            end
            ddo_pkg::S_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.op = ddo_pkg::OP_OUT;
                    n_state  = ddo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ddo_pkg::S_IDLE;
            end
        endcase
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ddo_pkg::OP_OUT) |-> !i_status.out_full)
        else $error("output register loaded while a result is still waiting");

    a_primed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_primed) |=> (r_state == ddo_pkg::S_MW))
        else $error("primed item did not start the sequence");

    a_first_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_primed) |=> (r_state == ddo_pkg::S_IDLE && r_primed))
        else $error("first item did not only record its stamp");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ddo_pkg::S_DF) |=> (r_state == ddo_pkg::S_POS))
        else $error("division did not end after its correction step");

endmodule
`default_nettype wire
